// File: src/ssx_pkg.sv
// Shared types and constants for the segment selector translator.
// No dependencies; the modules and the testbench import this package.
`default_nettype none

package ssx_pkg;

  // Command codes carried by an input transfer
  localparam logic [1:0] CMD_WRITE     = 2'd0;
  localparam logic [1:0] CMD_TRANSLATE = 2'd1;
  localparam logic [1:0] CMD_REVERSE   = 2'd2;

  // Segment kind codes of a translate result
  localparam logic [2:0] KIND_GDT     = 3'd0;
  localparam logic [2:0] KIND_INVALID = 3'd1;
  localparam logic [2:0] KIND_NULL    = 3'd2;
  localparam logic [2:0] KIND_CODE32  = 3'd3;
  localparam logic [2:0] KIND_CODE    = 3'd4;
  localparam logic [2:0] KIND_DATA    = 3'd5;

  // Selector layout: index in 15..3, table indicator in bit 2, RPL in 1..0
  localparam int          SEL_TI_BIT      = 2;
  localparam int          SEL_INDEX_W     = 13;
  localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;
  localparam logic [15:0] CODE32_SELECTOR = 16'h005B;
  localparam logic [2:0]  LDT_TI          = 3'h4;
  localparam logic [2:0]  RPL_THREE       = 3'h3;

  // Number of slots a write transfer can reach (slot_index is 8 bits)
  localparam int WRITE_REACH = 256;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] limit;
    logic        is_code;
    logic        is_wide;
  } entry_t;

  typedef struct packed {
    logic        status;
    logic [31:0] linear_out;
    logic [15:0] selector_out;
    logic [15:0] offset_out;
    logic [2:0]  segment_kind;
    logic        is_wide_out;
  } result_t;

endpackage

`default_nettype wire

// File: src/ssx_in_if.sv
// Input channel of the segment selector translator: valid/ready plus command payload.
// Depends on nothing.
`default_nettype none

interface ssx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [15:0] selector;
  logic [15:0] offset;
  logic [31:0] linear;
  logic [7:0]  slot_index;
  logic [31:0] slot_base;
  logic [31:0] slot_limit;
  logic        slot_is_code;
  logic        slot_is_wide;

  modport source (
    output valid, cmd, selector, offset, linear, slot_index, slot_base, slot_limit,
           slot_is_code, slot_is_wide,
    input  ready
  );
  modport sink (
    input  valid, cmd, selector, offset, linear, slot_index, slot_base, slot_limit,
           slot_is_code, slot_is_wide,
    output ready
  );
endinterface

`default_nettype wire

// File: src/ssx_out_if.sv
// Result channel of the segment selector translator: valid/ready plus result payload.
// Depends on nothing.
`default_nettype none

interface ssx_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [31:0] linear_out;
  logic [15:0] selector_out;
  logic [15:0] offset_out;
  logic [2:0]  segment_kind;
  logic        is_wide_out;

  modport source (
    output valid, status, linear_out, selector_out, offset_out, segment_kind, is_wide_out,
    input  ready
  );
  modport sink (
    input  valid, status, linear_out, selector_out, offset_out, segment_kind, is_wide_out,
    output ready
  );
endinterface

`default_nettype wire

// File: src/ssx_table.sv
// Descriptor table: one synchronous memory of slot entries with a registered read,
// plus per-slot valid bits cleared at reset. Depends on ssx_pkg.
`default_nettype none

module ssx_table #(
  parameter int DEPTH = 256
) (
  input  wire                                          clk,
  input  wire                                          rst,
  input  wire                                          wr_en,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
  input  wire ssx_pkg::entry_t                         wr_entry,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
  output ssx_pkg::entry_t                              rd_entry,
  output logic                                         rd_valid
);
  import ssx_pkg::*;

  entry_t             mem [DEPTH];
  logic [DEPTH-1:0]   slot_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_entry <= mem[rd_addr];
    rd_valid <= slot_valid[rd_addr];
  end

  // A slot never written reads with rd_valid low, i.e. free
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr_en) begin
      slot_valid[wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: src/ssx_engine.sv
// Command sequencer: writes slots, translates selectors from one table read, and
// scans the table one slot per cycle for reverse lookups. Depends on ssx_pkg, ssx_in_if.
`default_nettype none

module ssx_engine #(
  parameter int TABLE_SLOTS = 256,
  parameter int DEPTH       = 256
) (
  input  wire                                          clk,
  input  wire                                          rst,
  ssx_in_if.sink                                       in_ch,
  output logic                                         wr_en,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  output ssx_pkg::entry_t                              wr_entry,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  input  wire ssx_pkg::entry_t                         rd_entry,
  input  wire                                          rd_valid,
  output logic                                         res_valid,
  input  wire                                          res_ready,
  output ssx_pkg::result_t                             res
);
  import ssx_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TRANS = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]             state, state_next;
  logic [AW-1:0]          rd_idx, rd_idx_next;
  logic [15:0]            sel_q;
  logic [15:0]            off_q;
  logic [31:0]            lin_q;
  result_t                res_next;

  logic                   accept;
  logic [SEL_INDEX_W-1:0] in_idx;
  logic [31:0]            cur_base;
  logic [31:0]            seg_end;
  logic                   scan_hit;
  logic [AW-1:0]          rd_idx_inc;

  assign in_ch.ready = !rst && (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_idx      = in_ch.selector[15:3];
  assign res_valid   = (state == S_EMIT);
  assign rd_idx_inc  = AW'(rd_idx + 1'b1);

  assign wr_en    = accept && (in_ch.cmd == CMD_WRITE) &&
                    (32'(in_ch.slot_index) < 32'(TABLE_SLOTS));
  assign wr_addr  = AW'(in_ch.slot_index);
  assign wr_entry = '{base: in_ch.slot_base, limit: in_ch.slot_limit,
                      is_code: in_ch.slot_is_code, is_wide: in_ch.slot_is_wide};

  // Free or never-written slots have a zero base
  assign cur_base = rd_valid ? rd_entry.base : '0;
  assign seg_end  = cur_base + rd_entry.limit;
  assign scan_hit = (cur_base != '0) && (lin_q >= cur_base) && (lin_q < seg_end);

  always_comb begin
    rd_addr = rd_idx;
    if (state == S_IDLE) begin
      rd_addr = (in_ch.cmd == CMD_REVERSE) ? '0 : AW'(in_idx);
    end else if (state == S_SCAN) begin
      rd_addr = rd_idx_inc;
    end
  end

  always_comb begin
    state_next  = state;
    rd_idx_next = rd_idx;
    res_next    = res;
    case (state)
      S_IDLE: begin
        if (accept) begin
          res_next = '0;
          case (in_ch.cmd)
            CMD_TRANSLATE: begin
              res_next.is_wide_out = 1'b1;
              if (!in_ch.selector[SEL_TI_BIT]) begin
                res_next.segment_kind = KIND_GDT;
                res_next.linear_out   = {13'd0, in_ch.selector, 3'd0} +
                                        {16'd0, in_ch.offset};
                state_next            = S_EMIT;
              end else if (32'(in_idx) >= 32'(TABLE_SLOTS)) begin
                res_next.status       = 1'b1;
                res_next.linear_out   = ALL_ONES;
                res_next.segment_kind = KIND_INVALID;
                state_next            = S_EMIT;
              end else if (32'(in_idx) >= 32'(DEPTH)) begin
                // Beyond write reach: always free, and never slot 0
                res_next.status       = 1'b1;
                res_next.linear_out   = ALL_ONES;
                res_next.segment_kind = KIND_NULL;
                state_next            = S_EMIT;
              end else begin
                state_next = S_TRANS;
              end
            end
            CMD_REVERSE: begin
              rd_idx_next = '0;
              state_next  = S_SCAN;
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_TRANS: begin
        res_next             = '0;
        res_next.is_wide_out = 1'b1;
        if (cur_base == '0) begin
          res_next.segment_kind = KIND_NULL;
          if (sel_q[15:3] == '0) begin
            res_next.linear_out = {16'd0, off_q};
          end else begin
            res_next.status     = 1'b1;
            res_next.linear_out = ALL_ONES;
          end
        end else begin
          res_next.linear_out  = cur_base + {16'd0, off_q};
          res_next.is_wide_out = rd_entry.is_wide;
          if (sel_q == CODE32_SELECTOR) begin
            res_next.segment_kind = KIND_CODE32;
          end else begin
            res_next.segment_kind = rd_entry.is_code ? KIND_CODE : KIND_DATA;
          end
        end
        state_next = S_EMIT;
      end
      S_SCAN: begin
        if (scan_hit) begin
          res_next              = '0;
          res_next.linear_out   = lin_q;
          res_next.selector_out = {13'(rd_idx), LDT_TI | RPL_THREE};
          res_next.offset_out   = lin_q[15:0] - cur_base[15:0];
          state_next            = S_EMIT;
        end else if (32'(rd_idx) == 32'(DEPTH - 1)) begin
          res_next            = '0;
          res_next.status     = 1'b1;
          res_next.linear_out = ALL_ONES;
          state_next          = S_EMIT;
        end else begin
          rd_idx_next = rd_idx_inc;
        end
      end
      S_EMIT: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_idx_next;
    res    <= res_next;
    if (accept) begin
      sel_q <= in_ch.selector;
      off_q <= in_ch.offset;
      lin_q <= in_ch.linear;
    end
  end

endmodule

`default_nettype wire

// File: src/segment_selector_translator.sv
// Top level of the segment selector translator: sequencer, descriptor table and
// output register. Depends on ssx_pkg, ssx_in_if, ssx_out_if, ssx_table, ssx_engine.
//
// One item is worked on at a time; a finished result sits in the output register so
// the next item is taken while it waits. If that register is still held when the next
// result is ready, the sequencer holds the result and takes no input until it frees.
// A write or an unused command is done once accepted. A translate that needs the table
// goes through accept, one table read and result; a GDT selector or an index past the
// table goes through accept and result only. A reverse lookup reads the table through
// its single read port, one slot per cycle from slot 0 upward, and stops at the first
// hit or after slot min(TABLE_SLOTS,256) - 1.
// Only the first 256 slots can be written, so only those are stored; higher slots
// read as free. The table is empty right after reset (per-slot valid bits, no
// clearing pass), so items are accepted on the first cycle after reset.
`default_nettype none

module segment_selector_translator #(
  parameter int TABLE_SLOTS = 256
) (
  input  wire        clk,
  input  wire        rst,
  ssx_in_if.sink     in_ch,
  ssx_out_if.source  out_ch
);
  import ssx_pkg::*;

  localparam int DEPTH = (TABLE_SLOTS < WRITE_REACH) ? TABLE_SLOTS : WRITE_REACH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;
  logic [AW-1:0] rd_addr;
  entry_t        rd_entry;
  logic          rd_valid;
  logic          res_valid;
  logic          res_ready;
  result_t       res;
  result_t       out_q;
  logic          out_valid;

  ssx_table #(
    .DEPTH (DEPTH)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry),
    .rd_valid (rd_valid)
  );

  ssx_engine #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .DEPTH       (DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .rd_addr   (rd_addr),
    .rd_entry  (rd_entry),
    .rd_valid  (rd_valid),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Output register frees when empty or when its transfer completes
  assign res_ready = !out_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.status       = out_q.status;
  assign out_ch.linear_out   = out_q.linear_out;
  assign out_ch.selector_out = out_q.selector_out;
  assign out_ch.offset_out   = out_q.offset_out;
  assign out_ch.segment_kind = out_q.segment_kind;
  assign out_ch.is_wide_out  = out_q.is_wide_out;

endmodule

`default_nettype wire

// File: src/ssx_checker.sv
// Port-level assertions for segment_selector_translator, attached with a bind.
// Depends on ssx_pkg and the top level's port names.
`default_nettype none

module ssx_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_ready,
  input wire [1:0]  in_cmd,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_status,
  input wire [31:0] out_linear
);
  import ssx_pkg::*;

  // Result held until its transfer completes
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  // A failing result always carries an all-ones address
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status) |-> (out_linear == ALL_ONES))
    else $error("failing result without all-ones address");

  // A slot write produces no result
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_cmd == CMD_WRITE) && !out_valid) |=> !out_valid)
    else $error("result appeared after a slot write");

  // A lookup blocks the input for at least the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && ((in_cmd == CMD_TRANSLATE) || (in_cmd == CMD_REVERSE)))
      |=> !in_ready)
    else $error("input taken while a lookup is in progress");

  // Output empty right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind segment_selector_translator ssx_checker u_ssx_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_cmd     (in_ch.cmd),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_linear (out_ch.linear_out)
);

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for segment_selector_translator: drives descriptor writes, selector translations
// and reverse lookups, predicts every result from a shadow descriptor table and checks it.
// Depends on ssx_pkg, ssx_in_if, ssx_out_if and the RTL under src.

module tb_top;
  import ssx_pkg::*;

  localparam int TABLE_SLOTS = 256;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1450;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] selector;
    logic [15:0] offset;
    logic [31:0] linear;
    logic [7:0]  slot_index;
    logic [31:0] slot_base;
    logic [31:0] slot_limit;
    logic        slot_is_code;
    logic        slot_is_wide;
  } ldt_request_t;

  // Shadow descriptor table plus the queue of results still owed by the block
  class ldt_scoreboard;
    logic [31:0] seg_base [TABLE_SLOTS];
    logic [31:0] seg_limit [TABLE_SLOTS];
    bit          seg_code [TABLE_SLOTS];
    bit          seg_wide [TABLE_SLOTS];
    result_t     awaited[$];
    int unsigned faults;

    function new();
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        seg_base[i] = '0;
        seg_limit[i] = '0;
        seg_code[i] = 1'b0;
        seg_wide[i] = 1'b0;
      end
      faults = 0;
    endfunction

    function void flag(string msg);
      faults++;
      if (faults <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    function result_t translate_selector(logic [15:0] sel, logic [15:0] off);
      result_t r;
      logic [12:0] idx;
      r = '0;
      idx = sel[15:3];
      r.is_wide_out = 1'b1;
      if (!sel[SEL_TI_BIT]) begin
        r.linear_out = {13'd0, sel, 3'd0} + {16'd0, off};
        r.segment_kind = KIND_GDT;
      end else if (idx >= TABLE_SLOTS) begin
        r.status = 1'b1;
        r.linear_out = ALL_ONES;
        r.segment_kind = KIND_INVALID;
      end else if (seg_base[idx] == '0) begin
        r.segment_kind = KIND_NULL;
        // a free slot 0 passes the offset through untouched
        if (idx != 0) begin
          r.status = 1'b1;
          r.linear_out = ALL_ONES;
        end else begin
          r.linear_out = {16'd0, off};
        end
      end else begin
        r.linear_out = seg_base[idx] + {16'd0, off};
        if (sel == CODE32_SELECTOR) r.segment_kind = KIND_CODE32;
        else r.segment_kind = seg_code[idx] ? KIND_CODE : KIND_DATA;
        r.is_wide_out = seg_wide[idx];
      end
      return r;
    endfunction

    function result_t find_segment(logic [31:0] lin);
      result_t r;
      logic [31:0] seg_end;
      logic [31:0] gap;
      logic [12:0] idx;
      r = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        if (seg_base[i] != '0) begin
          // end wraps modulo 2^32, so a wrapped segment can never match
          seg_end = seg_base[i] + seg_limit[i];
          if (lin >= seg_base[i] && lin < seg_end) begin
            idx = 13'(i);
            gap = lin - seg_base[i];
            r.linear_out = lin;
            r.selector_out = {idx, LDT_TI | RPL_THREE};
            r.offset_out = gap[15:0];
            return r;
          end
        end
      end
      r.status = 1'b1;
      r.linear_out = ALL_ONES;
      return r;
    endfunction

    function void note_request(ldt_request_t req);
      case (req.cmd)
        CMD_WRITE: begin
          if (req.slot_index < TABLE_SLOTS) begin
            seg_base[req.slot_index] = req.slot_base;
            seg_limit[req.slot_index] = req.slot_limit;
            seg_code[req.slot_index] = req.slot_is_code;
            seg_wide[req.slot_index] = req.slot_is_wide;
          end
        end
        CMD_TRANSLATE: awaited.push_back(translate_selector(req.selector, req.offset));
        CMD_REVERSE: awaited.push_back(find_segment(req.linear));
        default: ;
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("%0t: unexpected result st %0d lin %h sel %h off %h kind %0d wide %0d",
                       $time, got.status, got.linear_out, got.selector_out, got.offset_out,
                       got.segment_kind, got.is_wide_out));
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status || got.linear_out !== want.linear_out ||
          got.selector_out !== want.selector_out || got.offset_out !== want.offset_out ||
          got.segment_kind !== want.segment_kind || got.is_wide_out !== want.is_wide_out)
        flag($sformatf({"%0t: mismatch expected st %0d lin %h sel %h off %h kind %0d wide %0d",
                        " / actual st %0d lin %h sel %h off %h kind %0d wide %0d"},
                       $time, want.status, want.linear_out, want.selector_out,
                       want.offset_out, want.segment_kind, want.is_wide_out,
                       got.status, got.linear_out, got.selector_out, got.offset_out,
                       got.segment_kind, got.is_wide_out));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm = 1'b0;
  int   quiet_cycles = 0;
  ldt_scoreboard sb;

  ssx_in_if  in_ch ();
  ssx_out_if out_ch ();

  segment_selector_translator #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 17);
  endfunction

  function automatic ldt_request_t scrambled_req();
    ldt_request_t r;
    r.cmd = 2'($urandom_range(3));
    r.selector = 16'($urandom);
    r.offset = 16'($urandom);
    r.linear = $urandom;
    r.slot_index = 8'($urandom);
    r.slot_base = $urandom;
    r.slot_limit = $urandom;
    r.slot_is_code = 1'($urandom_range(1));
    r.slot_is_wide = 1'($urandom_range(1));
    return r;
  endfunction

  function automatic ldt_request_t write_req(logic [7:0] slot, logic [31:0] base,
                                             logic [31:0] limit, bit code, bit wide);
    ldt_request_t r;
    r = scrambled_req();
    r.cmd = CMD_WRITE;
    r.slot_index = slot;
    r.slot_base = base;
    r.slot_limit = limit;
    r.slot_is_code = code;
    r.slot_is_wide = wide;
    return r;
  endfunction

  function automatic ldt_request_t translate_req(logic [15:0] sel, logic [15:0] off);
    ldt_request_t r;
    r = scrambled_req();
    r.cmd = CMD_TRANSLATE;
    r.selector = sel;
    r.offset = off;
    return r;
  endfunction

  function automatic ldt_request_t reverse_req(logic [31:0] lin);
    ldt_request_t r;
    r = scrambled_req();
    r.cmd = CMD_REVERSE;
    r.linear = lin;
    return r;
  endfunction

  // Hold valid until the transfer completes; leave it high for a back-to-back item
  task automatic send(input ldt_request_t req);
    while (take_break()) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= req.cmd;
    in_ch.selector <= req.selector;
    in_ch.offset <= req.offset;
    in_ch.linear <= req.linear;
    in_ch.slot_index <= req.slot_index;
    in_ch.slot_base <= req.slot_base;
    in_ch.slot_limit <= req.slot_limit;
    in_ch.slot_is_code <= req.slot_is_code;
    in_ch.slot_is_wide <= req.slot_is_wide;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(req);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready)
        sb.check_result({out_ch.status, out_ch.linear_out, out_ch.selector_out,
                         out_ch.offset_out, out_ch.segment_kind, out_ch.is_wide_out});
      out_ch.ready <= !take_break();
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    ldt_request_t req;
    int unsigned roll;
    int unsigned pick;
    int unsigned slot;
    sb = new();
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_WRITE;
    in_ch.selector = '0;
    in_ch.offset = '0;
    in_ch.linear = '0;
    in_ch.slot_index = '0;
    in_ch.slot_base = '0;
    in_ch.slot_limit = '0;
    in_ch.slot_is_code = 1'b0;
    in_ch.slot_is_wide = 1'b0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table: miss, free slot 0, free slot, index past the table, GDT extremes
    send(reverse_req(32'h0000_0000));
    send(translate_req(16'h0004, 16'hFFFF));
    send(translate_req(16'h000C, 16'h0001));
    send(translate_req(16'hFFFF, 16'h1234));
    send(translate_req(16'hFFFB, 16'hFFFF));
    send(translate_req(16'h0000, 16'h0000));
    send(translate_req(CODE32_SELECTOR, 16'h1234));
    // slot 0 and slot 3 wrap their end past 2^32; slots 7 and 8 overlap
    send(write_req(8'd0, 32'hFFFF_FFF0, 32'h0000_0020, 1'b1, 1'b1));
    send(write_req(8'd255, 32'hFFFF_0000, 32'h0000_FFFF, 1'b0, 1'b0));
    send(write_req(8'd3, 32'h0000_1000, ALL_ONES, 1'b0, 1'b1));
    send(write_req(8'd7, 32'h0000_1000, 32'h0000_0100, 1'b1, 1'b0));
    send(write_req(8'd8, 32'h0000_1080, 32'h0000_1000, 1'b0, 1'b1));
    send(translate_req(16'h0004, 16'hFFFF));
    send(translate_req(16'h07FF, 16'h0010));
    send(translate_req(16'h003D, 16'h0042));
    send(reverse_req(32'h0000_1080));
    send(reverse_req(32'h0000_1100));
    send(reverse_req(32'hFFFF_FFFE));
    send(reverse_req(ALL_ONES));
    send(reverse_req(32'h0000_1000));
    req = scrambled_req();
    req.cmd = CMD_UNUSED;
    send(req);
    send(write_req(8'd7, 32'h0000_0000, 32'h0000_0100, 1'b1, 1'b1));
    send(translate_req(16'h003C, 16'h0000));
    send(reverse_req(32'h0000_1080));
    send(write_req(8'd0, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 500 && n < 800);
      roll = $urandom_range(99);
      req = scrambled_req();
      if (roll < 25) begin
        req.cmd = CMD_WRITE;
        if ($urandom_range(9) < 7) req.slot_index = 8'($urandom_range(15));
        // clustered bases make overlaps, so first-match order gets exercised
        pick = $urandom_range(9);
        if (pick == 0) req.slot_base = '0;
        else if (pick < 5) req.slot_base = $urandom_range(64, 1) << 12;
        pick = $urandom_range(9);
        if (pick < 5) req.slot_limit = $urandom_range(32'h3000);
        else if (pick == 5) req.slot_limit = '0;
        else if (pick == 6) req.slot_limit = ALL_ONES;
      end else if (roll < 60) begin
        req.cmd = CMD_TRANSLATE;
        pick = $urandom_range(19);
        if (pick < 12) begin
          req.selector[15:3] = 13'($urandom_range(15));
          req.selector[SEL_TI_BIT] = 1'b1;
        end else if (pick < 15) begin
          req.selector[15:3] = 13'($urandom_range(255));
          req.selector[SEL_TI_BIT] = 1'b1;
        end
      end else if (roll < 95) begin
        req.cmd = CMD_REVERSE;
        slot = ($urandom_range(9) < 7) ? $urandom_range(15) : $urandom_range(255);
        // aim inside a live segment most of the time
        if ($urandom_range(9) < 6 && sb.seg_base[slot] != '0)
          req.linear = sb.seg_base[slot] +
                       ((sb.seg_limit[slot] == '0) ? 32'd0 : $urandom % sb.seg_limit[slot]);
      end else begin
        req.cmd = CMD_UNUSED;
      end
      send(req);
    end
    calm = 1'b0;
    in_ch.valid <= 1'b0;

    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.faults == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
